// ===== rtl/core/bsc_pkg.sv =====
// Shared types and constants for the safety check block.
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

   localparam int NUM_PROCS = 5;
   localparam int NUM_RES   = 3;

   localparam int CMD_W   = 2;
   localparam int PROC_W  = 3;
   localparam int RES_W   = 2;
   localparam int COUNT_W = 8;
   localparam int POOL_W  = 11;
   localparam int CNT_W   = $clog2(NUM_PROCS + 1);

   localparam logic [POOL_W-1:0] POOL_MAX = {POOL_W{1'b1}};

   localparam logic [CMD_W-1:0] CMD_LOAD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_MAX   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_AVAIL = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RUN        = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [PROC_W-1:0]  proc_index;
      logic [RES_W-1:0]   res_index;
      logic [COUNT_W-1:0] count_value;
   } req_type;

   typedef struct packed {
      logic [PROC_W-1:0] granted_proc;
      logic              is_grant;
      logic              last_flag;
   } rsp_type;

   typedef logic [NUM_RES-1:0][POOL_W-1:0]  pool_type;
   typedef logic [NUM_RES-1:0][COUNT_W-1:0] count_vec_type;

   // shared scan control, same for every cell
   typedef struct packed {
      logic step;        // token moves one cell down the chain
      logic take;        // the cell holding a hit is granted
      logic clear_done;  // new run: every process unfinished again
   } cell_ctrl_type;

   // table write, select already decoded per cell
   typedef struct packed {
      logic               wr_alloc;
      logic               wr_max;
      logic [RES_W-1:0]   res_index;
      logic [COUNT_W-1:0] value;
   } cell_wr_type;

endpackage

`default_nettype wire

// ===== rtl/core/bsc_cell.sv =====
// One process cell: allocation and maximum rows, finished bit and scan token.
`timescale 1ns / 1ps
`default_nettype none

module bsc_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire bsc_pkg::cell_ctrl_type  ctrl_i,
   input  wire bsc_pkg::cell_wr_type    wr_i,
   input  wire bsc_pkg::pool_type       pool_i,
   input  wire                          tok_prev_i,
   output logic                         tok_o,
   output logic                         hit_o,
   output bsc_pkg::count_vec_type       alloc_o
);
   import bsc_pkg::*;

   count_vec_type alloc_ff, alloc_in;
   count_vec_type max_ff, max_in;
   logic          done_ff, done_in;
   logic          tok_ff, tok_in;
   logic          fits;
   logic [COUNT_W-1:0] need;

   always_comb begin
      fits = 1'b1;
      need = '0;
      for (int r = 0; r < NUM_RES; r++) begin
         need = (max_ff[r] > alloc_ff[r]) ? (max_ff[r] - alloc_ff[r]) : '0;
         if (POOL_W'(need) > pool_i[r]) begin
            fits = 1'b0;
         end
      end
   end

   assign hit_o   = tok_ff & ~done_ff & fits;
   assign alloc_o = hit_o ? alloc_ff : '0;
   assign tok_o   = tok_ff;

   always_comb begin
      alloc_in = alloc_ff;
      max_in   = max_ff;
      for (int r = 0; r < NUM_RES; r++) begin
         if (wr_i.res_index == RES_W'(r)) begin
            if (wr_i.wr_alloc) begin
               alloc_in[r] = wr_i.value;
            end
            if (wr_i.wr_max) begin
               max_in[r] = wr_i.value;
            end
         end
      end
      tok_in  = ctrl_i.step ? tok_prev_i : tok_ff;
      done_in = done_ff;
      if (ctrl_i.clear_done) begin
         done_in = 1'b0;
      end else if (ctrl_i.take && hit_o) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff <= '0;
         max_ff   <= '0;
         done_ff  <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         alloc_ff <= alloc_in;
         max_ff   <= max_in;
         done_ff  <= done_in;
         tok_ff   <= tok_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/bankers_safety_check.sv =====
// Top level: request decode, scan control, resource pool and result register.
`timescale 1ns / 1ps
`default_nettype none

// Banker's safety check. Load requests (allocation, maximum, available) are taken
// whenever idle; out-of-range indexes are dropped. A run request clears the finished
// marks and passes a scan token down a chain of NUM_PROCS process cells, one cell
// per cycle until a cell fits or the last cell is reached. The first unfinished cell
// whose need fits the pool in every resource type is granted: its allocation is
// added to the pool (saturating) and, unless every process is now granted, the token
// restarts at cell 0. A round in which no cell fits ends the run with an unsafe
// result. A grant or the unsafe result waits while the result register is held.
// The next request is taken once the run has issued its final result.

module bankers_safety_check (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire bsc_pkg::req_type   req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output bsc_pkg::rsp_type        rsp_data
);
   import bsc_pkg::*;

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type         state_ff, state_in;
   pool_type          pool_ff, pool_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   cell_ctrl_type               ctrl;
   logic                        restart;
   cell_wr_type [NUM_PROCS-1:0] wr;
   logic [NUM_PROCS-1:0]        tok;
   logic [NUM_PROCS-1:0]        chain;
   logic [NUM_PROCS-1:0]        hit;
   count_vec_type [NUM_PROCS-1:0] alloc_sel;

   count_vec_type     grant_alloc;
   logic [PROC_W-1:0] grant_proc;
   logic              any_hit;
   logic              at_end;
   logic              out_free;
   logic              accept;
   logic              res_ok;
   logic              proc_ok;
   logic [POOL_W:0]   sum;

   genvar gi;
   generate
      for (gi = 0; gi < NUM_PROCS; gi++) begin : g_cell
         bsc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl_i     (ctrl),
            .wr_i       (wr[gi]),
            .pool_i     (pool_ff),
            .tok_prev_i (chain[gi]),
            .tok_o      (tok[gi]),
            .hit_o      (hit[gi]),
            .alloc_o    (alloc_sel[gi])
         );
      end
   endgenerate

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign res_ok    = 32'(req_data.res_index) < NUM_RES;
   assign proc_ok   = 32'(req_data.proc_index) < NUM_PROCS;

   // token chain; a restart clears the chain and injects a token at cell 0
   always_comb begin
      chain[0] = restart;
      for (int i = 1; i < NUM_PROCS; i++) begin
         chain[i] = tok[i-1] & ~restart;
      end
   end

   // at most one cell holds the token, so OR-merging picks the hit cell
   always_comb begin
      grant_alloc = '0;
      grant_proc  = '0;
      for (int i = 0; i < NUM_PROCS; i++) begin
         grant_alloc = grant_alloc | alloc_sel[i];
         if (hit[i]) begin
            grant_proc = PROC_W'(i);
         end
      end
      any_hit = |hit;
      at_end  = tok[NUM_PROCS-1] & ~hit[NUM_PROCS-1];
   end

   always_comb begin
      for (int i = 0; i < NUM_PROCS; i++) begin
         wr[i].wr_alloc  = accept && req_data.cmd == CMD_LOAD_ALLOC && res_ok && proc_ok
                           && req_data.proc_index == PROC_W'(i);
         wr[i].wr_max    = accept && req_data.cmd == CMD_LOAD_MAX && res_ok && proc_ok
                           && req_data.proc_index == PROC_W'(i);
         wr[i].res_index = req_data.res_index;
         wr[i].value     = req_data.count_value;
      end
   end

   always_comb begin
      state_in        = state_ff;
      pool_in         = pool_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_in          = rsp_ff;
      ctrl.step       = 1'b0;
      ctrl.take       = 1'b0;
      ctrl.clear_done = 1'b0;
      restart         = 1'b0;
      sum             = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.cmd == CMD_LOAD_AVAIL) begin
                  if (res_ok) begin
                     for (int r = 0; r < NUM_RES; r++) begin
                        if (req_data.res_index == RES_W'(r)) begin
                           pool_in[r] = POOL_W'(req_data.count_value);
                        end
                     end
                  end
               end else if (req_data.cmd == CMD_RUN) begin
                  ctrl.clear_done = 1'b1;
                  ctrl.step       = 1'b1;
                  restart         = 1'b1;
                  cnt_in          = '0;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (any_hit) begin
               if (out_free) begin
                  ctrl.take    = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in.granted_proc = grant_proc;
                  rsp_in.is_grant     = 1'b1;
                  rsp_in.last_flag    = (cnt_ff == CNT_W'(NUM_PROCS - 1));
                  for (int r = 0; r < NUM_RES; r++) begin
                     sum = {1'b0, pool_ff[r]} + (POOL_W + 1)'(grant_alloc[r]);
                     pool_in[r] = (sum > (POOL_W + 1)'(POOL_MAX)) ? POOL_MAX
                                                                  : sum[POOL_W-1:0];
                  end
                  if (cnt_ff == CNT_W'(NUM_PROCS - 1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     cnt_in    = cnt_ff + 1'b1;
                     ctrl.step = 1'b1;
                     restart   = 1'b1;
                  end
               end
            end else if (at_end) begin
               if (out_free) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.granted_proc = '0;
                  rsp_in.is_grant     = 1'b0;
                  rsp_in.last_flag    = 1'b1;
                  state_in            = ST_IDLE;
               end
            end else begin
               ctrl.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pool_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== dv/bsc_sequence_scoreboard.sv =====
// Scoreboard for the safety check: predicts grant sequences and compares results.
`timescale 1ns / 1ps
`default_nettype none

module bsc_sequence_scoreboard (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_ready,
   input  wire bsc_pkg::req_type   req_data,
   input  wire                     rsp_valid,
   input  wire                     rsp_ready,
   input  wire bsc_pkg::rsp_type   rsp_data,
   output int                      outstanding,
   output int                      failures
);
   import bsc_pkg::*;

   logic [COUNT_W-1:0] alloc_tab [NUM_PROCS][NUM_RES];
   logic [COUNT_W-1:0] max_tab   [NUM_PROCS][NUM_RES];
   logic [POOL_W-1:0]  pool      [NUM_RES];

   rsp_type expected_grants [$];
   rsp_type want;
   int      error_count = 0;

   function automatic logic proc_fits(int p);
      logic [COUNT_W-1:0] need;
      for (int r = 0; r < NUM_RES; r++) begin
         need = (max_tab[p][r] > alloc_tab[p][r]) ? max_tab[p][r] - alloc_tab[p][r] : '0;
         if (POOL_W'(need) > pool[r])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic predict_safe_sequence();
      logic [NUM_PROCS-1:0] finished;
      logic [POOL_W:0]      sum;
      rsp_type              g;
      int                   pick;
      finished = '0;
      for (int round = 0; round < NUM_PROCS; round++) begin
         pick = -1;
         for (int p = 0; p < NUM_PROCS; p++) begin
            if (pick < 0 && !finished[p] && proc_fits(p))
               pick = p;
         end
         if (pick < 0) begin
            // unsafe: no unfinished process fits the pool
            g.granted_proc = '0;
            g.is_grant     = 1'b0;
            g.last_flag    = 1'b1;
            expected_grants = {expected_grants, g};
            return;
         end
         for (int r = 0; r < NUM_RES; r++) begin
            sum = (POOL_W+1)'(pool[r]) + (POOL_W+1)'(alloc_tab[pick][r]);
            pool[r] = (sum > (POOL_W+1)'(POOL_MAX)) ? POOL_MAX : sum[POOL_W-1:0];
         end
         finished[pick]  = 1'b1;
         g.granted_proc  = PROC_W'(pick);
         g.is_grant      = 1'b1;
         g.last_flag     = (round == NUM_PROCS - 1);
         expected_grants = {expected_grants, g};
      end
   endtask

   task automatic apply_request(req_type r);
      case (r.cmd)
         CMD_LOAD_ALLOC: begin
            if (r.proc_index < NUM_PROCS && r.res_index < NUM_RES)
               alloc_tab[r.proc_index][r.res_index] = r.count_value;
         end
         CMD_LOAD_MAX: begin
            if (r.proc_index < NUM_PROCS && r.res_index < NUM_RES)
               max_tab[r.proc_index][r.res_index] = r.count_value;
         end
         CMD_LOAD_AVAIL: begin
            if (r.res_index < NUM_RES)
               pool[r.res_index] = POOL_W'(r.count_value);
         end
         default: predict_safe_sequence();
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PROCS; p++) begin
            for (int r = 0; r < NUM_RES; r++) begin
               alloc_tab[p][r] = '0;
               max_tab[p][r]   = '0;
            end
         end
         for (int r = 0; r < NUM_RES; r++)
            pool[r] = '0;
         expected_grants.delete();
      end else begin
         if (req_valid && req_ready)
            apply_request(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               $error("result with none expected: granted_proc %0d is_grant %0d last_flag %0d",
                      rsp_data.granted_proc, rsp_data.is_grant, rsp_data.last_flag);
               error_count++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_data.granted_proc !== want.granted_proc) begin
                  $error("granted_proc: expected %0d, got %0d",
                         want.granted_proc, rsp_data.granted_proc);
                  error_count++;
               end
               if (rsp_data.is_grant !== want.is_grant) begin
                  $error("is_grant: expected %0d, got %0d", want.is_grant, rsp_data.is_grant);
                  error_count++;
               end
               if (rsp_data.last_flag !== want.last_flag) begin
                  $error("last_flag: expected %0d, got %0d",
                         want.last_flag, rsp_data.last_flag);
                  error_count++;
               end
            end
         end
      end
      outstanding <= expected_grants.size();
      failures    <= error_count;
   end

endmodule

`default_nettype wire

// ===== dv/bankers_safety_check_test.sv =====
// Testbench top: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 1ps
`default_nettype none

module bankers_safety_check_test;
   import bsc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int TARGET_ITEMS = 180;
   localparam int PHASE_ITEMS  = 45;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_ready = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;

   int outstanding;
   int failures;
   int cycle_count   = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   int send_pcts  [4] = '{0, 77, 0, 9};
   int stall_pcts [4] = '{0, 0, 77, 9};

   always #5 clock = ~clock;

   bankers_safety_check DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   bsc_sequence_scoreboard scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .outstanding  (outstanding),
      .failures     (failures)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic req_type make_req(logic [CMD_W-1:0] c, logic [PROC_W-1:0] p,
                                        logic [RES_W-1:0] r, logic [COUNT_W-1:0] v);
      req_type q;
      q.cmd         = c;
      q.proc_index  = p;
      q.res_index   = r;
      q.count_value = v;
      return q;
   endfunction

   // called at a clock edge; returns at the edge where the request is taken
   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic send_run();
      send_request(make_req(CMD_RUN, PROC_W'($urandom), RES_W'($urandom),
                            COUNT_W'($urandom)));
   endtask

   function automatic logic [COUNT_W-1:0] pick_count(int hi);
      int roll;
      roll = $urandom_range(99);
      if (roll < 8)
         return '0;
      if (roll < 16)
         return '1;
      return COUNT_W'($urandom_range(hi));
   endfunction

   // whole new state: mostly needs that fit a modest pool, a few heavy holders
   task automatic load_scenario();
      logic [COUNT_W-1:0] a;
      logic [COUNT_W-1:0] m;
      int                 t;
      for (int p = 0; p < NUM_PROCS; p++) begin
         for (int r = 0; r < NUM_RES; r++) begin
            a = ($urandom_range(99) < 15) ? COUNT_W'($urandom_range(255, 200))
                                          : COUNT_W'($urandom_range(50));
            if ($urandom_range(99) < 80) begin
               t = a + $urandom_range(60);
               m = (t > 255) ? 8'd255 : COUNT_W'(t);
            end else begin
               m = COUNT_W'($urandom_range(a));
            end
            send_request(make_req(CMD_LOAD_ALLOC, PROC_W'(p), RES_W'(r), a));
            send_request(make_req(CMD_LOAD_MAX, PROC_W'(p), RES_W'(r), m));
         end
      end
      for (int r = 0; r < NUM_RES; r++)
         send_request(make_req(CMD_LOAD_AVAIL, PROC_W'($urandom), RES_W'(r),
                               COUNT_W'($urandom_range(120, 20))));
   endtask

   task automatic send_edit();
      logic [CMD_W-1:0] c;
      c = CMD_W'($urandom_range(2));
      send_request(make_req(c, PROC_W'($urandom_range(NUM_PROCS - 1)),
                            RES_W'($urandom_range(NUM_RES - 1)),
                            pick_count(c == CMD_LOAD_ALLOC ? 60 : 150)));
   endtask

   initial begin
      int phase;
      int next_phase_at;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty tables, blocked process, pool load, clamped need
      send_run();
      send_request(make_req(CMD_LOAD_MAX, 3'd0, 2'd0, 8'd255));
      send_run();
      send_request(make_req(CMD_LOAD_AVAIL, 3'd0, 2'd0, 8'd255));
      send_run();
      send_request(make_req(CMD_LOAD_ALLOC, 3'd4, 2'd2, 8'd255));
      send_request(make_req(CMD_LOAD_ALLOC, 3'd3, 2'd1, 8'd255));
      send_request(make_req(CMD_LOAD_ALLOC, 3'd2, 2'd0, 8'd255));
      // out-of-range indexes must leave the state alone
      send_request(make_req(CMD_LOAD_ALLOC, 3'd7, 2'd1, 8'haa));
      send_request(make_req(CMD_LOAD_MAX, 3'd5, 2'd0, 8'h55));
      send_request(make_req(CMD_LOAD_AVAIL, 3'd7, 2'd3, 8'h55));
      send_request(make_req(CMD_LOAD_ALLOC, 3'd1, 2'd3, 8'hff));
      send_run();
      // heavy allocation in one resource drives the pool into saturation
      for (int p = 0; p < 4; p++)
         send_request(make_req(CMD_LOAD_ALLOC, PROC_W'(p), 2'd2, 8'd255));
      send_run();
      send_run();
      send_run();
      wait_for_results();

      phase         = 0;
      next_phase_at = items_sent + PHASE_ITEMS;
      while (items_sent < TARGET_ITEMS) begin
         if (items_sent >= next_phase_at) begin
            wait_for_results();
            phase         = (phase + 1) % 4;
            send_idle_pct = send_pcts[phase];
            stall_pct     = stall_pcts[phase];
            next_phase_at = items_sent + PHASE_ITEMS;
         end
         if ($urandom_range(99) < 15)
            load_scenario();
         else
            repeat ($urandom_range(5)) send_edit();
         if ($urandom_range(99) < 12)
            send_request(make_req(CMD_W'($urandom), PROC_W'($urandom), RES_W'($urandom),
                                  COUNT_W'($urandom)));
         send_run();
      end

      wait_for_results();
      repeat (40) @(posedge clock);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/bsc_pkg.sv
rtl/core/bsc_cell.sv
rtl/core/bankers_safety_check.sv
dv/bsc_sequence_scoreboard.sv
dv/bankers_safety_check_test.sv
